FILE: hdl/qde_pkg.sv
// ----------------------------------------------------------------------------
// qde_pkg
// Types and constants shared by the queue delay estimator modules.
// ----------------------------------------------------------------------------
package qde_pkg;

  localparam int PORT_W  = 2;
  localparam int LEN_W   = 16;
  localparam int TOS_W   = 8;
  localparam int PS_W    = 16;
  localparam int BYTES_W = 27;
  localparam int PROD_W  = BYTES_W + PS_W;
  localparam int SUM_W   = 46;
  localparam int DELAY_W = 36;
  localparam int CNT_W   = 11;
  localparam int STEP_W  = $clog2(SUM_W);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = PS_W;

  localparam logic [PS_W-1:0]  PS_PER_BYTE_RST = PS_W'(801);
  localparam logic [TOS_W-1:0] TOS_LIMIT_RST   = TOS_W'(4);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PS_PER_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOS_LIMIT   = 1'b1;

  typedef struct packed {
    logic [PORT_W-1:0] port_index;
    logic [LEN_W-1:0]  packet_length;
    logic [TOS_W-1:0]  tos;
    logic              last;
  } in_t;

  typedef struct packed {
    logic [PORT_W-1:0]  port_out;
    logic [DELAY_W-1:0] queue_delay_ps;
    logic [CNT_W-1:0]   sampled_count;
    logic [CNT_W-1:0]   snapshot_size;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // absorb the accepted packet
    logic div_start;  // load the divider
    logic div_step;   // one quotient bit
    logic update;     // smooth, store and publish the estimate
    logic clear;      // close the snapshot
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic eligible;   // snapshot may update its port
    logic div_last;   // final quotient bit this cycle
    logic out_busy;   // result register still held by the sink
  } sts_t;

endpackage

FILE: hdl/qde_ctrl.sv
// ----------------------------------------------------------------------------
// qde_ctrl
// Sequencer: streams packets, drains the product pipe and, for an eligible
// snapshot, runs the divide and commits the per-port update.
// ----------------------------------------------------------------------------
module qde_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_stall_o,
  input  qde_pkg::sts_t sts_i,
  output qde_pkg::cmd_t cmd_o
);
  import qde_pkg::*;

  typedef enum logic [2:0] {
    S_RUN, S_DRAIN1, S_DRAIN2, S_CHECK, S_DIV, S_UPD
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_stall_o = (state_q != S_RUN);
  assign accept     = in_valid_i && (state_q == S_RUN);

  always_comb begin
    cmd_o           = '0;
    cmd_o.take      = accept;
    cmd_o.div_start = (state_q == S_CHECK) && sts_i.eligible;
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.update    = (state_q == S_UPD) && !sts_i.out_busy;
    cmd_o.clear     = ((state_q == S_CHECK) && !sts_i.eligible) || cmd_o.update;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
    end else begin
      unique case (state_q)
        S_RUN: begin
          if (accept && in_last_i) state_q <= S_DRAIN1;
        end
        // wait for the last product to land in the sum
        S_DRAIN1: state_q <= S_DRAIN2;
        S_DRAIN2: state_q <= S_CHECK;
        S_CHECK: begin
          state_q <= sts_i.eligible ? S_DIV : S_RUN;
        end
        S_DIV: begin
          if (sts_i.div_last) state_q <= S_UPD;
        end
        S_UPD: begin
          if (!sts_i.out_busy) state_q <= S_RUN;
        end
        default: state_q <= S_RUN;
      endcase
    end
  end

endmodule

FILE: hdl/qde_dp.sv
// ----------------------------------------------------------------------------
// qde_dp
// Datapath: configuration, snapshot accumulators, product pipe, bit-serial
// divider, per-port estimate store and result register.
// ----------------------------------------------------------------------------
module qde_dp #(
  parameter int NUM_PORTS    = 4,
  parameter int MAX_SNAPSHOT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [qde_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [qde_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  qde_pkg::in_t                      in_data_i,
  input  qde_pkg::cmd_t                     cmd_i,
  output qde_pkg::sts_t                     sts_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output qde_pkg::out_t                     out_data_o
);
  import qde_pkg::*;

  localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  logic [PS_W-1:0]    ps_per_byte_q;
  logic [TOS_W-1:0]   tos_limit_q;

  logic [BYTES_W-1:0] bytes_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   samp_q;
  logic [CNT_W-1:0]   snap_q;
  logic [PORT_W-1:0]  port_q;

  logic [BYTES_W-1:0] mul_a_q;
  logic               mul_v_q;
  logic [PROD_W-1:0]  prod_q;
  logic               prod_v_q;

  logic [SUM_W-1:0]   quo_q;
  logic [CNT_W-1:0]   rem_q;
  logic [STEP_W-1:0]  step_q;

  logic [DELAY_W-1:0] port_delay_q [NUM_PORTS];
  logic               out_valid_q;
  out_t               out_q;

  logic               full;
  logic [BYTES_W:0]   bytes_add;
  logic [BYTES_W-1:0] bytes_d;
  logic               sampled;
  logic [SUM_W:0]     sum_add;
  logic [CNT_W:0]     rem_sh;
  logic               rem_ge;
  logic [CNT_W:0]     rem_sub;
  logic [IDX_W-1:0]   idx;
  logic [DELAY_W-1:0] avg;
  logic [DELAY_W-1:0] old;
  logic [DELAY_W:0]   mix;
  logic [DELAY_W-1:0] est;

  assign full      = 32'(snap_q) >= MAX_SNAPSHOT;
  assign bytes_add = {1'b0, bytes_q} + {{(BYTES_W + 1 - LEN_W){1'b0}}, in_data_i.packet_length};
  assign bytes_d   = bytes_add[BYTES_W] ? '1 : bytes_add[BYTES_W-1:0];
  assign sampled   = in_data_i.tos <= tos_limit_q;
  assign sum_add   = {1'b0, sum_q} + (SUM_W + 1)'(prod_q);

  // restoring division, one quotient bit a cycle
  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, samp_q};
  assign rem_sub = rem_sh - {1'b0, samp_q};

  assign idx = IDX_W'(port_q);
  assign avg = (|quo_q[SUM_W-1:DELAY_W]) ? '1 : quo_q[DELAY_W-1:0];
  assign old = port_delay_q[idx];
  assign mix = {1'b0, old} + {1'b0, avg};
  assign est = (old == '0) ? avg : mix[DELAY_W:1];

  assign sts_o.eligible = (32'(port_q) < NUM_PORTS) && (snap_q >= CNT_W'(2)) &&
                          (samp_q != '0);
  assign sts_o.div_last = (step_q == STEP_W'(SUM_W - 1));
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_per_byte_q <= PS_PER_BYTE_RST;
      tos_limit_q   <= TOS_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PS_PER_BYTE: ps_per_byte_q <= cfg_data_i;
        CFG_TOS_LIMIT:   tos_limit_q   <= cfg_data_i[TOS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q  <= '0;
      sum_q    <= '0;
      samp_q   <= '0;
      snap_q   <= '0;
      mul_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      mul_v_q  <= cmd_i.take && !full && sampled;
      prod_v_q <= mul_v_q;
      if (cmd_i.clear) begin
        bytes_q <= '0;
        sum_q   <= '0;
        samp_q  <= '0;
        snap_q  <= '0;
      end else begin
        if (cmd_i.take && !full) begin
          bytes_q <= bytes_d;
          snap_q  <= snap_q + CNT_W'(1);
          if (sampled) samp_q <= samp_q + CNT_W'(1);
        end
        if (prod_v_q) sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      end
    end
  end

  // product pipe payload
  always_ff @(posedge clk_i) begin
    mul_a_q <= bytes_d;
    prod_q  <= mul_a_q * PROD_W'(ps_per_byte_q);
    if (cmd_i.take && in_data_i.last) port_q <= in_data_i.port_index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.div_start) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= sum_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) port_delay_q[i] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.update) begin
        port_delay_q[idx] <= est;
        if (est != '0) out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_q.port_out       <= port_q;
      out_q.queue_delay_ps <= est;
      out_q.sampled_count  <= samp_q;
      out_q.snapshot_size  <= snap_q;
    end
  end

endmodule

FILE: hdl/queue_delay_estimator.sv
// Takes one packet per cycle while a snapshot streams in.
// A last packet stalls the input while the multiply pipe drains and the snapshot
// is checked; when the snapshot can update its port, the stall also spans the
// bit-serial divide and the commit, longer while the sink holds the previous
// result. A result is registered at the commit, for a nonzero estimate only.
// Reset clears accumulators, per-port estimates and configuration to defaults.
// ----------------------------------------------------------------------------
// queue_delay_estimator
// Per-port queuing delay estimate from transmit-queue snapshots.
// ----------------------------------------------------------------------------
module queue_delay_estimator #(
  parameter int NUM_PORTS    = 4,
  parameter int MAX_SNAPSHOT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qde_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [qde_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  qde_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output qde_pkg::out_t                  out_data_o
);
  import qde_pkg::*;

  cmd_t cmd;
  sts_t sts;

  qde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qde_dp #(
    .NUM_PORTS    (NUM_PORTS),
    .MAX_SNAPSHOT (MAX_SNAPSHOT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
